### rtl/srrd_pkg.sv
`default_nettype none
package srrd_pkg;
    localparam int unsigned SETS        = 2048;
    localparam int unsigned WAYS        = 16;
    localparam int unsigned SIG_ENTRIES = 2048;
    localparam int unsigned HISTORY_LEN = 4;
    localparam int unsigned RRPV_WIDTH  = 2;
    localparam int unsigned ADDR_WIDTH  = 48;
    localparam int unsigned PC_WIDTH    = 48;
    localparam int unsigned SIG_WIDTH   = 11;
    localparam int unsigned SIG_SHIFT   = 6;
    localparam int unsigned SET_W       = $clog2(SETS);
    localparam int unsigned WAY_W       = $clog2(WAYS);
    localparam int unsigned SIGIDX_W    = $clog2(SIG_ENTRIES);
    localparam int unsigned HPTR_W      = $clog2(HISTORY_LEN);
    localparam int unsigned DELTA_W     = ADDR_WIDTH + 1;
    localparam logic [RRPV_WIDTH-1:0] RRPV_DISTANT = {RRPV_WIDTH{1'b1}};

    localparam logic [1:0] CFG_REUSE_THR  = 2'd0;
    localparam logic [1:0] CFG_STREAM_THR = 2'd1;
    localparam logic [1:0] CFG_DECAY      = 2'd2;

    localparam logic KIND_VICTIM = 1'b0;

    typedef struct packed {
        logic                  kind;
        logic [10:0]           set_index;
        logic [3:0]            way_index;
        logic [ADDR_WIDTH-1:0] phys_addr;
        logic [PC_WIDTH-1:0]   prog_counter;
        logic                  hit;
        logic                  victim_valid;
    } t_req;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       set_streaming;
    } t_rsp;

    typedef struct packed {
        logic [WAYS-1:0][RRPV_WIDTH-1:0] rrpv;
        logic [WAYS-1:0][SIG_WIDTH-1:0]  sig;
    } t_line_row;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]                prev_addr;
        logic [HISTORY_LEN-1:0][DELTA_W-1:0]  delta;
        logic [HPTR_W-1:0]                    ptr;
    } t_hist_row;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;
endpackage
`default_nettype wire

### rtl/srrd_req_if.sv
`default_nettype none
interface srrd_req_if;
    logic              valid;
    logic              ready;
    srrd_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/srrd_rsp_if.sv
`default_nettype none
interface srrd_rsp_if;
    logic              valid;
    logic              ready;
    srrd_pkg::t_rsp    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/ship_rrip_stream_dead_replacement_core.sv
`default_nettype none
// SHiP/SRRIP replacement engine with stream and dead-block detection.
// req_if carries one transaction per cache event: kind 0 asks for a victim
// way of a set, kind 1 reports a hit or a fill of (set, way).
// rsp_if returns exactly one transaction per request: the victim way (zero
// for updates) and the streaming flag of the set after the request.
// Config: i_cfg_we/i_cfg_idx/i_cfg_wdata write reuse_threshold (0),
// stream_match_threshold (1) and decay_interval (2); write only when idle.
// Victim requests and hits load the response register from ST_READ; fills load it
// from ST_FILL, after a second read of the signature counter table for the
// evicted line's signature. One transaction is in flight at a time, so a new
// request is accepted only after the current one has returned to ST_IDLE.
// State lives in four single-port synchronous RAMs indexed by set (line
// RRPV/signature row, dead-mark row, delta history row) and by signature.
// Reset: a clearing pass over all SETS (2048) entries initializes all RAMs;
// req_if.ready stays low meanwhile. Each time the fill counter reaches the
// decay interval, another pass over all SETS entries clears the dead-mark RAM,
// again with req_if.ready low.
// A stalled receiver holds the response register; a new request is taken
// only when that register is empty or drains in the same cycle.
module ship_rrip_stream_dead_replacement_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    srrd_req_if.sink          req_if,
    srrd_rsp_if.source        rsp_if,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_wdata
);
    localparam int unsigned SW = srrd_pkg::SET_W;
    localparam int unsigned GW = srrd_pkg::SIGIDX_W;
    localparam int unsigned W  = srrd_pkg::WAYS;
    localparam int unsigned RW = srrd_pkg::RRPV_WIDTH;
    localparam int unsigned DW = srrd_pkg::DELTA_W;
    localparam int unsigned HL = srrd_pkg::HISTORY_LEN;

    // RAMs
    srrd_pkg::t_line_row line_mem [srrd_pkg::SETS];
    logic [W-1:0]        dead_mem [srrd_pkg::SETS];
    srrd_pkg::t_hist_row hist_mem [srrd_pkg::SETS];
    logic [1:0]          ctr_mem  [srrd_pkg::SIG_ENTRIES];

    // config registers
    logic [1:0]  r_reuse_thr, r_stream_thr;
    logic [15:0] r_decay;

    srrd_pkg::t_state r_state, n_state;
    srrd_pkg::t_req   r_req;
    logic [SW-1:0]    r_clr_idx;
    logic             r_clr_full;
    logic [15:0]      r_fill_cnt;
    logic             r_out_valid;
    srrd_pkg::t_rsp   r_out;
    logic             r_stream;
    logic [1:0]       r_ctr_new;

    // RAM read data
    srrd_pkg::t_line_row r_line_rd;
    logic [W-1:0]        r_dead_rd;
    srrd_pkg::t_hist_row r_hist_rd;
    logic [1:0]          r_ctr_rd;

    // RAM write controls
    logic                line_we, dead_we, hist_we, ctr_we;
    logic [SW-1:0]       line_wa;
    logic [GW-1:0]       ctr_wa, ctr_ra;
    srrd_pkg::t_line_row line_wd;
    logic [W-1:0]        dead_wd;
    srrd_pkg::t_hist_row hist_wd;
    logic [1:0]          ctr_wd;
    logic                rd_en, ctr_rd_en;

    logic accept, out_take;
    logic [SW-1:0] in_set, cur_set;
    logic [GW-1:0] in_sig, cur_sig, old_sig;
    logic [srrd_pkg::WAY_W-1:0] cur_way;

    // victim / update datapath
    logic [RW-1:0]     mx, age;
    logic [3:0]        vic;
    logic              vic_found;
    srrd_pkg::t_line_row aged_row, hit_row, fill_row;
    srrd_pkg::t_hist_row new_hist;
    logic [DW-1:0]     delta;
    logic [1:0]        match_cnt;
    logic              streaming;
    logic [1:0]        hist_match_cnt;
    logic              hist_stream;
    logic [RW-1:0]     ins_rrpv;
    logic              mark;
    logic [16:0]       fill_next, interval;
    logic              decay_hit;
    srrd_pkg::t_rsp    n_out;
    logic              n_out_load;

    assign accept   = req_if.valid && req_if.ready;
    assign out_take = rsp_if.valid && rsp_if.ready;
    assign req_if.ready = (r_state == srrd_pkg::ST_IDLE) && (!r_out_valid || rsp_if.ready);
    assign rsp_if.valid   = r_out_valid;
    assign rsp_if.payload = r_out;

    function automatic logic [GW-1:0] sig_hash(input logic [srrd_pkg::PC_WIDTH-1:0] pc);
        logic [srrd_pkg::PC_WIDTH-1:0] h;
        h = pc ^ (pc >> srrd_pkg::SIG_SHIFT);
        return h[GW-1:0];
    endfunction

    assign in_set  = req_if.payload.set_index[SW-1:0];
    assign in_sig  = sig_hash(req_if.payload.prog_counter);
    assign cur_set = r_req.set_index[SW-1:0];
    assign cur_sig = sig_hash(r_req.prog_counter);
    assign cur_way = r_req.way_index[srrd_pkg::WAY_W-1:0];
    assign old_sig = r_line_rd.sig[cur_way][GW-1:0];

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reuse_thr  <= 2'd2;
            r_stream_thr <= 2'd3;
            r_decay      <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srrd_pkg::CFG_REUSE_THR:  r_reuse_thr  <= i_cfg_wdata[1:0];
                srrd_pkg::CFG_STREAM_THR: r_stream_thr <= i_cfg_wdata[1:0];
                srrd_pkg::CFG_DECAY:      r_decay      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // datapath
    always_comb begin
        mx = '0;
        for (int i = 0; i < W; i++) begin
            if (r_line_rd.rrpv[i] > mx) mx = r_line_rd.rrpv[i];
        end
        age = srrd_pkg::RRPV_DISTANT - mx;
        aged_row = r_line_rd;
        for (int i = 0; i < W; i++) begin
            aged_row.rrpv[i] = r_line_rd.rrpv[i] + age;
        end
        vic = '0;
        vic_found = 1'b0;
        for (int i = 0; i < W; i++) begin
            if (!vic_found && aged_row.rrpv[i] == srrd_pkg::RRPV_DISTANT) begin
                vic = 4'(i);
                vic_found = 1'b1;
            end
        end

        // victim requests report the stored history, untouched
        hist_match_cnt = '0;
        for (int i = 1; i < HL; i++) begin
            if (r_hist_rd.delta[i] == r_hist_rd.delta[0] && r_hist_rd.delta[0] != '0) begin
                hist_match_cnt = hist_match_cnt + 1'b1;
            end
        end
        hist_stream = (hist_match_cnt >= r_stream_thr);

        if (r_hist_rd.prev_addr != '0) begin
            delta = {1'b0, r_req.phys_addr} - {1'b0, r_hist_rd.prev_addr};
        end else begin
            delta = '0;
        end
        new_hist = r_hist_rd;
        new_hist.prev_addr = r_req.phys_addr;
        new_hist.delta[r_hist_rd.ptr] = delta;
        new_hist.ptr = r_hist_rd.ptr + 1'b1;

        match_cnt = '0;
        for (int i = 1; i < HL; i++) begin
            if (new_hist.delta[i] == new_hist.delta[0] && new_hist.delta[0] != '0) begin
                match_cnt = match_cnt + 1'b1;
            end
        end
        streaming = (match_cnt >= r_stream_thr);

        hit_row = r_line_rd;
        hit_row.rrpv[cur_way] = '0;

        ins_rrpv = srrd_pkg::RRPV_DISTANT;
        if (r_ctr_new >= r_reuse_thr) ins_rrpv = srrd_pkg::RRPV_DISTANT - 1'b1;
        if (r_stream || r_dead_rd[cur_way]) ins_rrpv = srrd_pkg::RRPV_DISTANT;
        mark = r_req.victim_valid && (r_line_rd.rrpv[cur_way] == srrd_pkg::RRPV_DISTANT);
        fill_row = r_line_rd;
        fill_row.rrpv[cur_way] = ins_rrpv;
        fill_row.sig[cur_way]  = r_req.prog_counter[srrd_pkg::SIG_WIDTH-1:0]
                               ^ r_req.prog_counter[srrd_pkg::SIG_WIDTH-1+srrd_pkg::SIG_SHIFT:
                                                    srrd_pkg::SIG_SHIFT];

        fill_next = {1'b0, r_fill_cnt} + 17'd1;
        interval  = (r_decay == '0) ? 17'h10000 : {1'b0, r_decay};
        decay_hit = (fill_next >= interval);
    end

    // control
    always_comb begin
        n_state    = r_state;
        rd_en      = accept;
        ctr_rd_en  = accept;
        ctr_ra     = in_sig;
        line_we = 1'b0; dead_we = 1'b0; hist_we = 1'b0; ctr_we = 1'b0;
        line_wa = cur_set;
        line_wd = hit_row;
        dead_wd = r_dead_rd;
        hist_wd = new_hist;
        ctr_wa  = cur_sig;
        ctr_wd  = r_ctr_rd;
        n_out      = r_out;
        n_out_load = 1'b0;
        unique case (r_state)
            srrd_pkg::ST_CLEAR: begin
                line_wa = r_clr_idx;
                dead_we = 1'b1;
                dead_wd = '0;
                line_we = r_clr_full;
                hist_we = r_clr_full;
                ctr_we  = r_clr_full;
                for (int i = 0; i < W; i++) begin
                    line_wd.rrpv[i] = srrd_pkg::RRPV_DISTANT;
                    line_wd.sig[i]  = '0;
                end
                hist_wd = '0;
                ctr_wa  = r_clr_idx[GW-1:0];
                ctr_wd  = 2'd1;
                if (r_clr_idx == SW'(srrd_pkg::SETS - 1)) n_state = srrd_pkg::ST_IDLE;
            end
            srrd_pkg::ST_IDLE: begin
                if (accept) n_state = srrd_pkg::ST_READ;
            end
            srrd_pkg::ST_READ: begin
                if (r_req.kind == srrd_pkg::KIND_VICTIM) begin
                    line_we = 1'b1;
                    line_wd = aged_row;
                    n_out.victim_way    = vic;
                    n_out.set_streaming = hist_stream;
                    n_out_load = 1'b1;
                    n_state = srrd_pkg::ST_IDLE;
                end else begin
                    hist_we = 1'b1;
                    n_out.victim_way    = '0;
                    n_out.set_streaming = streaming;
                    if (r_req.hit) begin
                        line_we = 1'b1;
                        line_wd = hit_row;
                        dead_we = 1'b1;
                        dead_wd = r_dead_rd;
                        dead_wd[cur_way] = 1'b0;
                        ctr_we = 1'b1;
                        ctr_wd = (r_ctr_rd == 2'd3) ? 2'd3 : r_ctr_rd + 2'd1;
                        n_out_load = 1'b1;
                        n_state = srrd_pkg::ST_IDLE;
                    end else begin
                        ctr_rd_en = 1'b1;
                        ctr_ra    = old_sig;
                        n_state   = srrd_pkg::ST_FILL;
                    end
                end
            end
            srrd_pkg::ST_FILL: begin
                line_we = 1'b1;
                line_wd = fill_row;
                dead_we = 1'b1;
                dead_wd = r_dead_rd;
                dead_wd[cur_way] = mark;
                ctr_we = mark;
                ctr_wa = old_sig;
                ctr_wd = (r_ctr_rd == 2'd0) ? 2'd0 : r_ctr_rd - 2'd1;
                n_out.victim_way    = '0;
                n_out.set_streaming = r_stream;
                n_out_load = 1'b1;
                n_state = decay_hit ? srrd_pkg::ST_CLEAR : srrd_pkg::ST_IDLE;
            end
            default: n_state = srrd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srrd_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_clr_full  <= 1'b1;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == srrd_pkg::ST_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (r_state == srrd_pkg::ST_CLEAR && n_state == srrd_pkg::ST_IDLE) begin
                r_clr_full <= 1'b0;
            end
            if (r_state == srrd_pkg::ST_FILL) begin
                r_fill_cnt <= decay_hit ? 16'd0 : fill_next[15:0];
            end
            if (n_out_load) r_out_valid <= 1'b1;
            else if (out_take) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) r_req <= req_if.payload;
        if (n_out_load) r_out <= n_out;
        if (r_state == srrd_pkg::ST_READ) begin
            r_stream  <= streaming;
            r_ctr_new <= r_ctr_rd;
        end
    end

    // RAMs
    always_ff @(posedge i_clk) begin
        if (line_we) line_mem[line_wa] <= line_wd;
        if (rd_en)   r_line_rd <= line_mem[in_set];
    end

    always_ff @(posedge i_clk) begin
        if (dead_we) dead_mem[line_wa] <= dead_wd;
        if (rd_en)   r_dead_rd <= dead_mem[in_set];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[line_wa] <= hist_wd;
        if (rd_en)   r_hist_rd <= hist_mem[in_set];
    end

    always_ff @(posedge i_clk) begin
        if (ctr_we)    ctr_mem[ctr_wa] <= ctr_wd;
        if (ctr_rd_en) r_ctr_rd <= ctr_mem[ctr_ra];
    end
endmodule
`default_nettype wire
